// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file of the filter.
// No dependencies; take in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8VF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8vf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTF8VF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8vf assertion failed");

`endif

// ----- rtl/core/utf8vf_pkg.sv -----
// Shared types, constants and scalar checks for the UTF-8 validating filter.
// No dependencies.
`default_nettype none

package utf8vf_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [7:0] ReplByte = 8'h5F;  // '_'

  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  typedef logic [CntW-1:0] res_cnt_t;

  // Results caused by one accepted input transaction.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    res_cnt_t                   count;
    logic                       has_byte;
    logic                       eos;
    logic                       str_valid;
  } burst_t;

  function automatic logic scalar_ok(logic [20:0] v);
    logic ok;
    ok = 1'b1;
    if (v >= 21'h110000)                      ok = 1'b0;
    if ((v & 21'h1FF800) == 21'h00D800)       ok = 1'b0;
    if (v >= 21'h00FDD0 && v <= 21'h00FDEF)   ok = 1'b0;
    if ((v & 21'h00FFFE) == 21'h00FFFE)       ok = 1'b0;
    return ok;
  endfunction

  // Smallest scalar that a sequence of the given length may encode.
  function automatic logic [20:0] min_scalar(logic [2:0] len);
    logic [20:0] m;
    unique case (len)
      SeqLen2: m = 21'h000080;
      SeqLen3: m = 21'h000800;
      default: m = 21'h010000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/utf8vf_if.sv -----
// Valid/ready channel interfaces for the filter's input and result streams.
// No dependencies.
`default_nettype none

interface utf8vf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface utf8vf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       string_valid;
  logic       last;
  logic       string_done;

  modport source (output valid, out_byte, has_byte, string_valid, last, string_done,
                  input ready);
  modport sink   (input valid, out_byte, has_byte, string_valid, last, string_done,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/utf8vf_dec.sv -----
// Sequence decoder: holds the pending-sequence state and works out the
// results of one input transaction in a single pass. Depends on utf8vf_pkg.
`default_nettype none

module utf8vf_dec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                eos_i,
  input  logic                filter_mode_i,
  output utf8vf_pkg::burst_t  burst_o
);

  logic [2:0][7:0] pend_q, pend_d;
  logic [1:0]      pcnt_q, pcnt_d;
  logic [2:0]      slen_q, slen_d;
  logic [20:0]     scal_q, scal_d;
  logic            err_q, err_d;

  logic [utf8vf_pkg::MaxResults-1:0][7:0] lst;
  utf8vf_pkg::res_cnt_t                   n, n_all;
  logic [20:0]                            sc_ext;
  logic                                   fin_ok;
  logic                                   do_start;
  logic                                   st_emit;
  logic [7:0]                             st_byte;

  assign sc_ext = {scal_q[14:0], in_byte_i[5:0]};
  assign fin_ok = (sc_ext >= utf8vf_pkg::min_scalar(slen_q)) && utf8vf_pkg::scalar_ok(sc_ext);

  always_comb begin
    pend_d   = pend_q;
    pcnt_d   = pcnt_q;
    slen_d   = slen_q;
    scal_d   = scal_q;
    err_d    = err_q;
    lst      = '0;
    n        = '0;
    n_all    = '0;
    do_start = 1'b0;
    st_emit  = 1'b0;
    st_byte  = utf8vf_pkg::ReplByte;

    // continue or close a pending sequence
    if (slen_q == utf8vf_pkg::SeqNone || pcnt_q == 2'd0) begin
      pcnt_d   = 2'd0;
      slen_d   = utf8vf_pkg::SeqNone;
      do_start = 1'b1;
    end else if (in_byte_i[7:6] != 2'b10) begin
      // broken sequence: held bytes become '_', breaking byte starts afresh
      for (int i = 0; i < 3; i++) begin
        if (i < int'(pcnt_q)) lst[i] = utf8vf_pkg::ReplByte;
      end
      n        = utf8vf_pkg::res_cnt_t'(pcnt_q);
      err_d    = 1'b1;
      pcnt_d   = 2'd0;
      slen_d   = utf8vf_pkg::SeqNone;
      scal_d   = '0;
      do_start = 1'b1;
    end else if ({1'b0, pcnt_q} + 3'd1 < slen_q) begin
      scal_d = sc_ext;
      for (int i = 0; i < 3; i++) begin
        if (pcnt_q == 2'(i)) pend_d[i] = in_byte_i;
      end
      pcnt_d = pcnt_q + 2'd1;
    end else begin
      // sequence complete
      for (int i = 0; i < 3; i++) begin
        if (i < int'(pcnt_q)) lst[i] = fin_ok ? pend_q[i] : utf8vf_pkg::ReplByte;
      end
      for (int i = 0; i < utf8vf_pkg::MaxResults; i++) begin
        if (i == int'(pcnt_q)) lst[i] = fin_ok ? in_byte_i : utf8vf_pkg::ReplByte;
      end
      n = utf8vf_pkg::res_cnt_t'(pcnt_q) + utf8vf_pkg::res_cnt_t'(1);
      if (!fin_ok) err_d = 1'b1;
      pcnt_d = 2'd0;
      slen_d = utf8vf_pkg::SeqNone;
      scal_d = '0;
    end

    // decode as a lead byte
    if (do_start) begin
      priority if (!in_byte_i[7]) begin
        st_emit = 1'b1;
        st_byte = in_byte_i;
      end else if (in_byte_i[7:5] == 3'b110) begin
        slen_d    = utf8vf_pkg::SeqLen2;
        scal_d    = {16'd0, in_byte_i[4:0]};
        pend_d[0] = in_byte_i;
        pcnt_d    = 2'd1;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        slen_d    = utf8vf_pkg::SeqLen3;
        scal_d    = {17'd0, in_byte_i[3:0]};
        pend_d[0] = in_byte_i;
        pcnt_d    = 2'd1;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        slen_d    = utf8vf_pkg::SeqLen4;
        scal_d    = {18'd0, in_byte_i[2:0]};
        pend_d[0] = in_byte_i;
        pcnt_d    = 2'd1;
      end else begin
        st_emit = 1'b1;
        err_d   = 1'b1;
      end
    end

    if (st_emit) begin
      for (int k = 0; k < utf8vf_pkg::MaxResults; k++) begin
        if (n == utf8vf_pkg::res_cnt_t'(k)) lst[k] = st_byte;
      end
      if (n != utf8vf_pkg::res_cnt_t'(utf8vf_pkg::MaxResults)) begin
        n = n + utf8vf_pkg::res_cnt_t'(1);
      end
    end

    // string ends mid-sequence: flush held bytes as '_'
    n_all = n;
    if (eos_i && slen_d != utf8vf_pkg::SeqNone) begin
      for (int k = 0; k < utf8vf_pkg::MaxResults; k++) begin
        if (k >= int'(n) && k < int'(n) + int'(pcnt_d)) lst[k] = utf8vf_pkg::ReplByte;
      end
      if (int'(n) + int'(pcnt_d) > utf8vf_pkg::MaxResults) begin
        n_all = utf8vf_pkg::res_cnt_t'(utf8vf_pkg::MaxResults);
      end else begin
        n_all = n + utf8vf_pkg::res_cnt_t'(pcnt_d);
      end
      err_d = 1'b1;
    end
  end

  always_comb begin
    burst_o.bytes     = lst;
    burst_o.has_byte  = filter_mode_i;
    burst_o.eos       = eos_i;
    burst_o.str_valid = !err_d;
    if (filter_mode_i) begin
      burst_o.count = n_all;
    end else begin
      burst_o.count = eos_i ? utf8vf_pkg::res_cnt_t'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 2'd0;
      slen_q <= utf8vf_pkg::SeqNone;
      scal_q <= '0;
      err_q  <= 1'b0;
      pend_q <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      if (eos_i) begin
        pcnt_q <= 2'd0;
        slen_q <= utf8vf_pkg::SeqNone;
        scal_q <= '0;
        err_q  <= 1'b0;
      end else begin
        pcnt_q <= pcnt_d;
        slen_q <= slen_d;
        scal_q <= scal_d;
        err_q  <= err_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_validate_filter.sv -----
// Top level of the UTF-8 validating filter: config register, decoder and
// result burst register. Depends on utf8vf_pkg, utf8vf_if and utf8vf_dec.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        in_byte[7:0], end_of_string
//   out_ch   out  valid/ready        out_byte[7:0], has_byte, string_valid,
//                                    last, string_done
//   cfg      in   cfg_we_i (no wait) cfg_wdata_i = filter_mode
//
// One input transaction is decoded in the cycle it is accepted; its 0..4
// results land in the burst register and leave one per cycle while
// out_ch.ready is high. Results hold the register until the last is taken,
// so input then runs at one byte a cycle while each byte yields at most one result.
// ready rises again in the cycle the last queued result is taken.
// Reset (async, active low) clears the decoder state, burst count and mode.
`default_nettype none

module utf8_validate_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  utf8vf_in_if.sink           in_ch,
  utf8vf_out_if.source        out_ch
);

  logic                filter_mode_q;
  logic                in_accept;
  logic                out_pop;
  utf8vf_pkg::burst_t  burst;

  // Result burst register: entry 0 is the head, pops shift down.
  logic [utf8vf_pkg::MaxResults-1:0][7:0] obytes_q, obytes_d;
  utf8vf_pkg::res_cnt_t                   ocnt_q, ocnt_d;
  logic                                   ohas_q, ohas_d;
  logic                                   oeos_q, oeos_d;
  logic                                   oval_q, oval_d;
  logic                                   out_last;

  // Mode register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      filter_mode_q <= cfg_wdata_i;
    end
  end

  // Take a new byte once the burst register is empty or about to be.
  assign in_ch.ready = (ocnt_q == '0)
                    || (ocnt_q == utf8vf_pkg::res_cnt_t'(1) && out_ch.ready);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_pop     = (ocnt_q != '0) && out_ch.ready;

  utf8vf_dec u_dec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .in_byte_i     (in_ch.in_byte),
    .eos_i         (in_ch.end_of_string),
    .filter_mode_i (filter_mode_q),
    .burst_o       (burst)
  );

  always_comb begin
    obytes_d = obytes_q;
    ocnt_d   = ocnt_q;
    ohas_d   = ohas_q;
    oeos_d   = oeos_q;
    oval_d   = oval_q;
    if (in_accept) begin
      // load wins: the burst register is empty or its last entry leaves now
      obytes_d = burst.bytes;
      ocnt_d   = burst.count;
      ohas_d   = burst.has_byte;
      oeos_d   = burst.eos;
      oval_d   = burst.str_valid;
    end else if (out_pop) begin
      obytes_d = {8'h00, obytes_q[utf8vf_pkg::MaxResults-1:1]};
      ocnt_d   = ocnt_q - utf8vf_pkg::res_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else begin
      ocnt_q <= ocnt_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    obytes_q <= obytes_d;
    ohas_q   <= ohas_d;
    oeos_q   <= oeos_d;
    oval_q   <= oval_d;
  end

  assign out_last            = (ocnt_q == utf8vf_pkg::res_cnt_t'(1));
  assign out_ch.valid        = (ocnt_q != '0);
  assign out_ch.out_byte     = ohas_q ? obytes_q[0] : 8'h00;
  assign out_ch.has_byte     = ohas_q;
  assign out_ch.last         = out_last;
  assign out_ch.string_done  = out_last && oeos_q;
  assign out_ch.string_valid = out_last && oeos_q && oval_q;

endmodule

`default_nettype wire

// ----- rtl/core/utf8vf_chk.sv -----
// Port-level checker for utf8_validate_filter, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module utf8vf_chk (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       has_byte_i,
  input  logic       string_valid_i,
  input  logic       last_i,
  input  logic       string_done_i
);

  logic        out_stall;
  logic [10:0] out_pay;
  logic        report_ok;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_pay   = {out_byte_i, has_byte_i, last_i, string_done_i};
  assign report_ok = string_done_i && (out_byte_i == 8'h00);

  // a stalled result transaction holds its payload
  `UTF8VF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_pay))
  `UTF8VF_ASSERT_IMPL(a_done_is_last, clk_i, rst_ni, out_valid_i && string_done_i, last_i)
  `UTF8VF_ASSERT_IMPL(a_valid_on_done, clk_i, rst_ni, out_valid_i && string_valid_i, string_done_i)
  // a result without a byte is only the validate-mode string report
  `UTF8VF_ASSERT_IMPL(a_nobyte_report, clk_i, rst_ni, out_valid_i && !has_byte_i, report_ok)

endmodule

bind utf8_validate_filter utf8vf_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .out_byte_i     (out_ch.out_byte),
  .has_byte_i     (out_ch.has_byte),
  .string_valid_i (out_ch.string_valid),
  .last_i         (out_ch.last),
  .string_done_i  (out_ch.string_done)
);

`default_nettype wire

// ----- sim/utf8vf_checker.sv -----
// Scoreboard for the UTF-8 validating filter: watches the input, config and result
// channels, predicts each transaction's results and compares them in order.
// Depends on utf8vf_pkg and utf8vf_if.

module utf8vf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  utf8vf_in_if        in_mon,
  utf8vf_out_if       out_mon,
  output int unsigned errors_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_valid;
    logic       last;
    logic       string_done;
  } filter_result_t;

  // Decoder shadow state
  logic        fmode;
  logic [7:0]  held [3];
  logic [1:0]  held_cnt;
  logic [2:0]  seq_len;
  logic [20:0] scalar;
  logic        err_seen;

  filter_result_t step_res [utf8vf_pkg::MaxResults];
  int             step_n;
  filter_result_t owed_results [$];
  int unsigned    mismatches;

  function automatic bit scalar_allowed(input logic [20:0] v);
    if (v >= 21'h110000) return 1'b0;
    if (v >= 21'h00D800 && v <= 21'h00DFFF) return 1'b0;
    if (v >= 21'h00FDD0 && v <= 21'h00FDEF) return 1'b0;
    if (v[15:1] == 15'h7FFF) return 1'b0;  // xFFFE / xFFFF in any plane
    return 1'b1;
  endfunction

  task automatic emit(input logic [7:0] b);
    if (!fmode || step_n >= utf8vf_pkg::MaxResults) return;
    step_res[step_n] = '{b, 1'b1, 1'b0, 1'b0, 1'b0};
    step_n++;
  endtask

  task automatic drop_held();
    for (int i = 0; i < held_cnt; i++) emit(utf8vf_pkg::ReplByte);
    err_seen = 1'b1;
    held_cnt = '0;
    seq_len  = utf8vf_pkg::SeqNone;
    scalar   = '0;
  endtask

  task automatic start_seq(input logic [7:0] b);
    if (b < 8'h80) begin
      emit(b);
      return;
    end
    if (b[7:5] == 3'b110) begin
      seq_len = utf8vf_pkg::SeqLen2;
      scalar  = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      seq_len = utf8vf_pkg::SeqLen3;
      scalar  = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      seq_len = utf8vf_pkg::SeqLen4;
      scalar  = {18'd0, b[2:0]};
    end else begin
      // stray continuation or F8..FF
      emit(utf8vf_pkg::ReplByte);
      err_seen = 1'b1;
      return;
    end
    held[0]  = b;
    held_cnt = 2'd1;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [20:0] floor_v;
    if (seq_len == utf8vf_pkg::SeqNone || held_cnt == 0) begin
      held_cnt = '0;
      seq_len  = utf8vf_pkg::SeqNone;
      start_seq(b);
      return;
    end
    if (b[7:6] != 2'b10) begin
      // broken sequence: flush it, then retry this byte as a lead
      drop_held();
      start_seq(b);
      return;
    end
    scalar = {scalar[14:0], b[5:0]};
    if (held_cnt + 1 < seq_len) begin
      held[held_cnt] = b;
      held_cnt++;
      return;
    end
    floor_v = (seq_len == utf8vf_pkg::SeqLen2) ? 21'h000080 :
              (seq_len == utf8vf_pkg::SeqLen3) ? 21'h000800 : 21'h010000;
    if (scalar >= floor_v && scalar_allowed(scalar)) begin
      for (int i = 0; i < held_cnt; i++) emit(held[i]);
      emit(b);
    end else begin
      for (int i = 0; i <= held_cnt; i++) emit(utf8vf_pkg::ReplByte);
      err_seen = 1'b1;
    end
    held_cnt = '0;
    seq_len  = utf8vf_pkg::SeqNone;
    scalar   = '0;
  endtask

  task automatic decode_input(input logic [7:0] b, input logic eos);
    step_n = 0;
    decode_byte(b);
    if (eos && seq_len != utf8vf_pkg::SeqNone) drop_held();
    if (eos && !fmode) begin
      step_res[0] = '0;
      step_n      = 1;
    end
    if (step_n > 0) begin
      step_res[step_n-1].last = 1'b1;
      if (eos) begin
        step_res[step_n-1].string_done  = 1'b1;
        step_res[step_n-1].string_valid = !err_seen;
      end
    end
    if (eos) begin
      err_seen = 1'b0;
      held_cnt = '0;
      seq_len  = utf8vf_pkg::SeqNone;
      scalar   = '0;
    end
    for (int i = 0; i < step_n; i++) owed_results.push_back(step_res[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_result();
    filter_result_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual byte %02h has_byte %0b",
               $time, out_mon.out_byte, out_mon.has_byte);
      mismatches++;
      return;
    end
    want = owed_results.pop_front();
    check_field("out_byte", want.out_byte, out_mon.out_byte);
    check_field("has_byte", want.has_byte, out_mon.has_byte);
    check_field("string_valid", want.string_valid, out_mon.string_valid);
    check_field("last", want.last, out_mon.last);
    check_field("string_done", want.string_done, out_mon.string_done);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmode      = 1'b0;
      held[0]    = '0;
      held[1]    = '0;
      held[2]    = '0;
      held_cnt   = '0;
      seq_len    = utf8vf_pkg::SeqNone;
      scalar     = '0;
      err_seen   = 1'b0;
      mismatches = 0;
      owed_results.delete();
    end else begin
      // results leaving now belong to earlier transactions
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) decode_input(in_mon.in_byte, in_mon.end_of_string);
      if (cfg_we_i) fmode = cfg_wdata_i;
    end
    errors_o      = mismatches;
    outstanding_o = owed_results.size();
  end

endmodule

// ----- sim/tb_utf8_validate_filter.sv -----
// Top of the UTF-8 validating filter testbench: clock, reset, stimulus, result
// back-pressure and verdict. Depends on utf8vf_pkg, utf8vf_if, utf8vf_checker
// and the filter RTL.

module tb_utf8_validate_filter;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_wdata;
  int unsigned fail_count;
  int unsigned open_results;
  int unsigned bytes_sent;

  // quiet = no idling on that side until the next random flip
  bit in_quiet;
  bit out_quiet;

  // bytes of the string being built, sent out by send_text
  logic [7:0] text_q [$];

  utf8vf_in_if  in_ch ();
  utf8vf_out_if out_ch ();

  utf8_validate_filter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  utf8vf_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .errors_o      (fail_count),
    .outstanding_o (open_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: worst case is roughly 130 transactions, each waiting out the longest input
  // gap and four results that each sit through the longest stall; the limit allows over
  // ten times that.
  initial begin
    #(12 * 300000);
    $display("simulation failed");
    $finish;
  end

  // Result side: per transaction, hold ready low for a random number of cycles.
  // ready is only dropped when a gap is actually drawn, so a back-to-back
  // transaction never sees it lowered and raised in one step.
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
      gap = out_quiet ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // Drop valid and wait until every predicted result has been taken. In validate
  // mode a non-final byte yields nothing, so let the decoder settle after that
  // before anything else touches the block.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (open_results != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_string <= eos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // close = mark the last byte as end of string; otherwise the string runs on
  task automatic send_text(input bit close);
    foreach (text_q[i]) send_byte(text_q[i], close && (i == text_q.size() - 1));
  endtask

  // Encode v in len bytes. Out-of-range and overlong values are encoded as asked.
  task automatic append_scalar(input logic [20:0] v, input int unsigned len);
    case (len)
      1: text_q.push_back({1'b0, v[6:0]});
      2: begin
        text_q.push_back({3'b110, v[10:6]});
        text_q.push_back({2'b10, v[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, v[15:12]});
        text_q.push_back({2'b10, v[11:6]});
        text_q.push_back({2'b10, v[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, v[20:18]});
        text_q.push_back({2'b10, v[17:12]});
        text_q.push_back({2'b10, v[11:6]});
        text_q.push_back({2'b10, v[5:0]});
      end
    endcase
  endtask

  // One random character: mostly well-formed sequences, with a share of each
  // reject reason, cut-off sequences and raw noise bytes.
  task automatic add_char();
    int unsigned kind;
    int unsigned len;
    int unsigned plane;
    logic [20:0] v;
    bit          cut;
    kind = $urandom_range(0, 99);
    cut  = 1'b0;
    if (kind >= 92) begin
      // noise: stray continuations, F8..FF, anything non-zero
      text_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    if (kind < 25) begin
      len = 1;
      v   = 21'($urandom_range(1, 'h7F));
    end else if (kind < 40) begin
      len = 2;
      v   = 21'($urandom_range('h80, 'h7FF));
    end else if (kind < 55) begin
      len = 3;
      v   = 21'($urandom_range('h800, 'hFFFF));
    end else if (kind < 65) begin
      len = 4;
      v   = 21'($urandom_range('h10000, 'h10FFFF));
    end else if (kind < 70) begin
      len = 3;  // surrogate
      v   = 21'($urandom_range('hD800, 'hDFFF));
    end else if (kind < 73) begin
      len = 3;  // FDD0..FDEF block
      v   = 21'($urandom_range('hFDD0, 'hFDEF));
    end else if (kind < 77) begin
      // noncharacter at the top of some plane
      plane = $urandom_range(0, 16);
      len   = (plane == 0) ? 3 : 4;
      v     = 21'((plane << 16) | 'hFFFE | $urandom_range(0, 1));
    end else if (kind < 81) begin
      len = 4;  // beyond the last plane
      v   = 21'($urandom_range('h110000, 'h1FFFFF));
    end else if (kind < 85) begin
      // overlong: value fits a shorter form
      len = $urandom_range(2, 4);
      v   = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
    end else begin
      // sequence cut short by whatever follows
      cut = 1'b1;
      len = $urandom_range(2, 4);
      v   = 21'($urandom_range(0, 'h10FFFF));
    end
    append_scalar(v, len);
    if (cut) repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
  endtask

  initial begin
    int unsigned goal;
    int unsigned phase_end;
    bit          first;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= 8'h20;
    in_ch.end_of_string <= 1'b0;
    bytes_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed string in filter mode: field extremes, a valid pair, overlong,
    // surrogate, the FDD0 block, beyond the last plane, a three-byte prefix
    // broken by an invalid lead (four results at once), a stray continuation,
    // a prefix broken by ASCII and a string that ends mid-sequence.
    write_mode(1'b1);
    text_q = '{8'h01,
               8'hC3, 8'hA9,
               8'hC0, 8'h80,
               8'hED, 8'hA0, 8'h80,
               8'hEF, 8'hB7, 8'h90,
               8'hF4, 8'h90, 8'h80, 8'h80,
               8'hF0, 8'h9F, 8'h82, 8'hFF,
               8'h80,
               8'hE2, 8'h41,
               8'hE2, 8'h82};
    send_text(1'b1);

    // Random phases. Each starts with a mode write once the block is drained,
    // which also makes the sender wait for all results. A phase may stop inside
    // a string, so decoding carries across a mode change.
    goal  = 110;
    first = 1'b1;
    while (bytes_sent < goal) begin
      write_mode(first ? 1'b0 : ($urandom_range(0, 1) == 1));
      first     = 1'b0;
      phase_end = bytes_sent + $urandom_range(12, 30);
      while (bytes_sent < phase_end && bytes_sent < goal) begin
        text_q.delete();
        repeat ($urandom_range(1, 6)) add_char();
        send_text($urandom_range(0, 3) != 0);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
